// ===== rtl/obbsat_pkg.sv =====
// shared constants and types for the oriented box pair collision test
package obbsat_pkg;

    localparam int POS_FRAC_BITS = 8;
    localparam int TRIG_BITS     = 16;

    localparam int POS_W   = 24;
    localparam int SIZE_W  = 12;
    localparam int ANG_W   = 16;

    localparam int U_W     = 15;
    localparam int Z2_W    = 31;
    localparam int I1_W    = 30;
    localparam int I2_W    = 31;
    localparam int MAG_W   = TRIG_BITS + 1;
    localparam int SC_W    = TRIG_BITS + 2;
    localparam int PROD_W  = SIZE_W + 1 + SC_W;
    localparam int EXP_W   = PROD_W + 1;
    localparam int RND_W   = EXP_W + POS_FRAC_BITS + 1;
    localparam int CRN_W   = POS_W + 3;
    localparam int DOT_W   = SC_W + CRN_W + 1;

    localparam logic [ANG_W-1:0] QUARTER = 16'h4000;
    localparam logic [I2_W-1:0]  SIN_A   = 31'd1686629713;
    localparam logic [I1_W-1:0]  SIN_B   = 30'd688904866;
    localparam logic [26:0]      SIN_C   = 27'd76016977;

    localparam int STAGES = 10;

    typedef struct packed {
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
        logic [SIZE_W-1:0]       w;
        logic [SIZE_W-1:0]       h;
    } geo_t;

endpackage

// ===== rtl/obbsat_req_if.sv =====
// input channel carrying one box pair per beat
interface obbsat_req_if;
    logic valid;
    logic ready;
    logic signed [obbsat_pkg::POS_W-1:0] a_pos_x;
    logic signed [obbsat_pkg::POS_W-1:0] a_pos_y;
    logic [obbsat_pkg::SIZE_W-1:0]       a_width;
    logic [obbsat_pkg::SIZE_W-1:0]       a_height;
    logic [obbsat_pkg::ANG_W-1:0]        a_angle;
    logic signed [obbsat_pkg::POS_W-1:0] b_pos_x;
    logic signed [obbsat_pkg::POS_W-1:0] b_pos_y;
    logic [obbsat_pkg::SIZE_W-1:0]       b_width;
    logic [obbsat_pkg::SIZE_W-1:0]       b_height;
    logic [obbsat_pkg::ANG_W-1:0]        b_angle;

    modport source (output valid, a_pos_x, a_pos_y, a_width, a_height, a_angle,
                    b_pos_x, b_pos_y, b_width, b_height, b_angle, input ready);
    modport sink   (input valid, a_pos_x, a_pos_y, a_width, a_height, a_angle,
                    b_pos_x, b_pos_y, b_width, b_height, b_angle, output ready);
endinterface

// output channel carrying one collision flag per beat
interface obbsat_rsp_if;
    logic valid;
    logic ready;
    logic overlap;

    modport source (output valid, overlap, input ready);
    modport sink   (input valid, overlap, output ready);
endinterface

// ===== rtl/obb_pair_collision_sat.sv =====
// oriented box pair separating axis test, ten stage pipeline
// throughput: one box pair per cycle; set by the fully pipelined sine units
// and the 64 projection multipliers, each stage stalls as a whole when rsp is held
// reset: rst_n asynchronous active low, clears the stage valid bits only
module obb_pair_collision_sat (
    input  logic clk,
    input  logic rst_n,
    obbsat_req_if.sink   req,
    obbsat_rsp_if.source rsp
);

    localparam int P = obbsat_pkg::POS_FRAC_BITS;
    localparam int T = obbsat_pkg::TRIG_BITS;

    logic adv;
    logic [obbsat_pkg::STAGES-1:0] vld_reg;

    // geometry pipeline, stages one to six
    obbsat_pkg::geo_t geo_reg [0:5][0:1];
    obbsat_pkg::geo_t geo_next [0:1];

    // sine lanes: sin a, cos a, sin b, cos b
    logic [obbsat_pkg::U_W-1:0]  u_reg   [0:3][0:3];
    logic                        neg_reg [0:3][0:3];
    logic [obbsat_pkg::Z2_W-1:0] z2_reg  [0:1][0:3];
    logic [obbsat_pkg::I1_W-1:0] i1_reg  [0:3];
    logic [obbsat_pkg::I2_W-1:0] i2_reg  [0:3];
    logic signed [obbsat_pkg::SC_W-1:0] sc_reg  [0:3];
    logic signed [obbsat_pkg::SC_W-1:0] sc6_reg [0:3];

    logic [obbsat_pkg::U_W-1:0] u_next [0:3];
    logic                       neg_next [0:3];
    logic [obbsat_pkg::Z2_W-1:0] z2_next [0:3];
    logic [obbsat_pkg::I1_W-1:0] i1_next [0:3];
    logic [obbsat_pkg::I2_W-1:0] i2_next [0:3];
    logic signed [obbsat_pkg::SC_W-1:0] sc_next [0:3];

    // per box products w*c, w*s, h*c, h*s
    logic signed [obbsat_pkg::PROD_W-1:0] wc_reg [0:1], ws_reg [0:1];
    logic signed [obbsat_pkg::PROD_W-1:0] hc_reg [0:1], hs_reg [0:1];
    logic signed [obbsat_pkg::PROD_W-1:0] wc_next [0:1], ws_next [0:1];
    logic signed [obbsat_pkg::PROD_W-1:0] hc_next [0:1], hs_next [0:1];
    logic [3:0] en6_reg, en7_reg, en8_reg, en9_reg;
    logic [3:0] en6_next;

    // corners and axes
    logic signed [obbsat_pkg::CRN_W-1:0] cx_reg [0:1][0:3], cy_reg [0:1][0:3];
    logic signed [obbsat_pkg::CRN_W-1:0] cx_next [0:1][0:3], cy_next [0:1][0:3];
    logic signed [obbsat_pkg::SC_W-1:0] ux_reg [0:3], uy_reg [0:3];
    logic signed [obbsat_pkg::SC_W-1:0] ux_next [0:3], uy_next [0:3];

    // projections
    logic signed [obbsat_pkg::DOT_W-1:0] dot_reg [0:3][0:1][0:3];
    logic signed [obbsat_pkg::DOT_W-1:0] dot_next [0:3][0:1][0:3];
    logic signed [obbsat_pkg::DOT_W-1:0] lo_reg [0:3][0:1], hi_reg [0:3][0:1];
    logic signed [obbsat_pkg::DOT_W-1:0] lo_next [0:3][0:1], hi_next [0:3][0:1];

    logic overlap_reg;
    logic overlap_next;

    assign adv       = !vld_reg[obbsat_pkg::STAGES-1] || rsp.ready;
    assign req.ready = adv;
    assign rsp.valid = vld_reg[obbsat_pkg::STAGES-1];
    assign rsp.overlap = overlap_reg;

    // stage 1: fold angles into the first quadrant
    always_comb
    begin
        logic [obbsat_pkg::ANG_W-1:0] ang;
        logic [obbsat_pkg::ANG_W-1:0] a_in [0:1];
        a_in[0] = req.a_angle;
        a_in[1] = req.b_angle;
        geo_next[0] = '{req.a_pos_x, req.a_pos_y, req.a_width, req.a_height};
        geo_next[1] = '{req.b_pos_x, req.b_pos_y, req.b_width, req.b_height};
        for (int l = 0; l < 4; l++)
        begin
            ang = (l % 2 == 1) ? a_in[l/2] + obbsat_pkg::QUARTER : a_in[l/2];
            u_next[l] = ang[14] ? obbsat_pkg::U_W'(obbsat_pkg::QUARTER)
                                  - obbsat_pkg::U_W'(ang[13:0])
                                : obbsat_pkg::U_W'(ang[13:0]);
            neg_next[l] = ang[15];
        end
    end

    // stages 2 to 5: polynomial sine, one multiply per stage
    always_comb
    begin
        logic [2*obbsat_pkg::U_W-1:0] sq;
        logic [obbsat_pkg::Z2_W+26:0] p1;
        logic [obbsat_pkg::Z2_W+obbsat_pkg::I1_W-1:0] p2;
        logic [obbsat_pkg::U_W+obbsat_pkg::I2_W-1:0] p3;
        logic [obbsat_pkg::U_W+obbsat_pkg::I2_W-15:0] rs;
        logic [obbsat_pkg::MAG_W-1:0] mag;
        for (int l = 0; l < 4; l++)
        begin
            sq = u_reg[0][l] * u_reg[0][l];
            z2_next[l] = {sq[obbsat_pkg::Z2_W-3:0], 2'b00};
            p1 = z2_reg[0][l] * obbsat_pkg::SIN_C;
            i1_next[l] = obbsat_pkg::SIN_B - obbsat_pkg::I1_W'(p1[obbsat_pkg::Z2_W+26:30]);
            p2 = z2_reg[1][l] * i1_reg[l];
            i2_next[l] = obbsat_pkg::SIN_A
                       - obbsat_pkg::I2_W'(p2[obbsat_pkg::Z2_W+obbsat_pkg::I1_W-1:30]);
            p3 = u_reg[3][l] * i2_reg[l];
            rs = p3[obbsat_pkg::U_W+obbsat_pkg::I2_W-1:14]
               + ((obbsat_pkg::U_W+obbsat_pkg::I2_W-14)'(1) << (29 - T));
            mag = rs[30-T +: obbsat_pkg::MAG_W];
            sc_next[l] = neg_reg[3][l] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        end
    end

    // stage 6: size times trig products, axis enables
    always_comb
    begin
        logic signed [obbsat_pkg::SIZE_W:0] ws, hs;
        for (int b = 0; b < 2; b++)
        begin
            ws = $signed({1'b0, geo_reg[4][b].w});
            hs = $signed({1'b0, geo_reg[4][b].h});
            wc_next[b] = ws * sc_reg[2*b+1];
            ws_next[b] = ws * sc_reg[2*b];
            hc_next[b] = hs * sc_reg[2*b+1];
            hs_next[b] = hs * sc_reg[2*b];
            en6_next[2*b]   = geo_reg[4][b].w != '0;
            en6_next[2*b+1] = geo_reg[4][b].h != '0;
        end
    end

    // stage 7: doubled corner coordinates and axes
    always_comb
    begin
        logic signed [obbsat_pkg::EXP_W-1:0] vx, vy;
        logic signed [obbsat_pkg::RND_W-1:0] tx, ty;
        logic signed [obbsat_pkg::CRN_W-1:0] base_x, base_y;
        for (int b = 0; b < 2; b++)
        begin
            base_x = (obbsat_pkg::CRN_W'(geo_reg[5][b].px) <<< 1)
                   + (obbsat_pkg::CRN_W'(geo_reg[5][b].w) << P);
            base_y = (obbsat_pkg::CRN_W'(geo_reg[5][b].py) <<< 1)
                   + (obbsat_pkg::CRN_W'(geo_reg[5][b].h) << P);
            for (int k = 0; k < 4; k++)
            begin
                vx = (k % 2 == 1) ? obbsat_pkg::EXP_W'(wc_reg[b]) : -obbsat_pkg::EXP_W'(wc_reg[b]);
                vx = (k / 2 == 1) ? vx - obbsat_pkg::EXP_W'(hs_reg[b])
                                  : vx + obbsat_pkg::EXP_W'(hs_reg[b]);
                vy = (k % 2 == 1) ? obbsat_pkg::EXP_W'(ws_reg[b]) : -obbsat_pkg::EXP_W'(ws_reg[b]);
                vy = (k / 2 == 1) ? vy + obbsat_pkg::EXP_W'(hc_reg[b])
                                  : vy - obbsat_pkg::EXP_W'(hc_reg[b]);
                tx = (obbsat_pkg::RND_W'(vx) <<< P) + (obbsat_pkg::RND_W'(1) <<< (T - 1));
                ty = (obbsat_pkg::RND_W'(vy) <<< P) + (obbsat_pkg::RND_W'(1) <<< (T - 1));
                tx = tx >>> T;
                ty = ty >>> T;
                cx_next[b][k] = base_x + obbsat_pkg::CRN_W'(tx);
                cy_next[b][k] = base_y + obbsat_pkg::CRN_W'(ty);
            end
            ux_next[2*b]   = -sc6_reg[2*b];
            uy_next[2*b]   = sc6_reg[2*b+1];
            ux_next[2*b+1] = sc6_reg[2*b+1];
            uy_next[2*b+1] = sc6_reg[2*b];
        end
    end

    // stage 8: dot products of every corner with every axis
    always_comb
    begin
        for (int a = 0; a < 4; a++)
            for (int b = 0; b < 2; b++)
                for (int k = 0; k < 4; k++)
                    dot_next[a][b][k] = obbsat_pkg::DOT_W'(ux_reg[a] * cx_reg[b][k])
                                      + obbsat_pkg::DOT_W'(uy_reg[a] * cy_reg[b][k]);
    end

    // stage 9: projection intervals, two level min/max tree
    always_comb
    begin
        logic signed [obbsat_pkg::DOT_W-1:0] l0, l1, h0, h1;
        for (int a = 0; a < 4; a++)
            for (int b = 0; b < 2; b++)
            begin
                l0 = (dot_reg[a][b][0] < dot_reg[a][b][1]) ? dot_reg[a][b][0] : dot_reg[a][b][1];
                h0 = (dot_reg[a][b][0] < dot_reg[a][b][1]) ? dot_reg[a][b][1] : dot_reg[a][b][0];
                l1 = (dot_reg[a][b][2] < dot_reg[a][b][3]) ? dot_reg[a][b][2] : dot_reg[a][b][3];
                h1 = (dot_reg[a][b][2] < dot_reg[a][b][3]) ? dot_reg[a][b][3] : dot_reg[a][b][2];
                lo_next[a][b] = (l0 < l1) ? l0 : l1;
                hi_next[a][b] = (h0 > h1) ? h0 : h1;
            end
    end

    // stage 10: any enabled separating axis clears the hit
    always_comb
    begin
        overlap_next = 1'b1;
        for (int a = 0; a < 4; a++)
            if (en9_reg[a] && ((lo_reg[a][0] > hi_reg[a][1]) || (hi_reg[a][0] < lo_reg[a][1])))
                overlap_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[obbsat_pkg::STAGES-2:0], req.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int b = 0; b < 2; b++)
            begin
                geo_reg[0][b] <= geo_next[b];
                for (int s = 1; s < 6; s++)
                    geo_reg[s][b] <= geo_reg[s-1][b];
                wc_reg[b] <= wc_next[b];
                ws_reg[b] <= ws_next[b];
                hc_reg[b] <= hc_next[b];
                hs_reg[b] <= hs_next[b];
                for (int k = 0; k < 4; k++)
                begin
                    cx_reg[b][k] <= cx_next[b][k];
                    cy_reg[b][k] <= cy_next[b][k];
                end
            end
            for (int l = 0; l < 4; l++)
            begin
                u_reg[0][l]   <= u_next[l];
                neg_reg[0][l] <= neg_next[l];
                for (int s = 1; s < 4; s++)
                begin
                    u_reg[s][l]   <= u_reg[s-1][l];
                    neg_reg[s][l] <= neg_reg[s-1][l];
                end
                z2_reg[0][l] <= z2_next[l];
                z2_reg[1][l] <= z2_reg[0][l];
                i1_reg[l]    <= i1_next[l];
                i2_reg[l]    <= i2_next[l];
                sc_reg[l]    <= sc_next[l];
                sc6_reg[l]   <= sc_reg[l];
                ux_reg[l]    <= ux_next[l];
                uy_reg[l]    <= uy_next[l];
            end
            for (int a = 0; a < 4; a++)
                for (int b = 0; b < 2; b++)
                begin
                    for (int k = 0; k < 4; k++)
                        dot_reg[a][b][k] <= dot_next[a][b][k];
                    lo_reg[a][b] <= lo_next[a][b];
                    hi_reg[a][b] <= hi_next[a][b];
                end
            en6_reg     <= en6_next;
            en7_reg     <= en6_reg;
            en8_reg     <= en7_reg;
            en9_reg     <= en8_reg;
            overlap_reg <= overlap_next;
        end
    end

endmodule

// ===== tb/tb_obb_pair_collision_sat.sv =====
// testbench for the oriented box pair collision block: scoreboard and drivers
`timescale 1ns / 1ps

class overlap_scoreboard;
    bit pending_q[$];
    int errors;

    function new();
        errors = 0;
    endfunction

    function void note_pair(bit expected);
        pending_q.insert(pending_q.size(), expected);
    endfunction

    task report(string msg);
        errors++;
        $display("%s", msg);
    endtask

    task check_flag(bit got);
        bit want;
        if (pending_q.size() == 0)
        begin
            report($sformatf("unexpected result beat overlap=%0d", got));
            return;
        end
        want = pending_q.pop_front();
        if (want !== got)
            report($sformatf("overlap mismatch: got %0d want %0d", got, want));
    endtask
endclass

module tb_obb_pair_collision_sat;

    typedef struct {
        logic signed [obbsat_pkg::POS_W-1:0] px;
        logic signed [obbsat_pkg::POS_W-1:0] py;
        logic [obbsat_pkg::SIZE_W-1:0]       w;
        logic [obbsat_pkg::SIZE_W-1:0]       h;
        logic [obbsat_pkg::ANG_W-1:0]        ang;
    } box_in_t;

    typedef struct {
        longint x[4];
        longint y[4];
        longint c;
        longint s;
        bit     w_nz;
        bit     h_nz;
    } corners_t;

    localparam int RESET_CYCLES = 7;
    localparam int IDLE_LIMIT   = 5000;
    localparam int N_RANDOM     = 730;

    logic clk;
    logic rst_n;
    obbsat_req_if req ();
    obbsat_rsp_if rsp ();
    overlap_scoreboard sb;
    int idle_cycles;

    obb_pair_collision_sat dut (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic longint quarter_sine(longint unsigned u);
        longint unsigned z, z2, i1, i2, y;
        z  = u << 16;
        z2 = (z * z) >> 30;
        i1 = 64'd76016977 * z2;
        i1 = 64'd688904866 - (i1 >> 30);
        i2 = 64'd1686629713 - ((z2 * i1) >> 30);
        y  = (z * i2) >> 30;
        return longint'((y + (64'd1 << (29 - obbsat_pkg::TRIG_BITS)))
                        >> (30 - obbsat_pkg::TRIG_BITS));
    endfunction

    function automatic longint sine_of(logic [obbsat_pkg::ANG_W-1:0] ang);
        longint v;
        logic [13:0] r;
        r = ang[13:0];
        v = ang[14] ? quarter_sine(16384 - r) : quarter_sine(r);
        return ang[15] ? -v : v;
    endfunction

    // floor division by 2^T of the rounded scaled value
    function automatic longint scale_round(longint v);
        longint t;
        t = v * (64'sd1 <<< obbsat_pkg::POS_FRAC_BITS)
          + (64'sd1 <<< (obbsat_pkg::TRIG_BITS - 1));
        return t >>> obbsat_pkg::TRIG_BITS;
    endfunction

    function automatic corners_t make_corners(box_in_t b);
        corners_t r;
        longint px, py, w, h, a, bb;
        px = longint'(b.px);
        py = longint'(b.py);
        w = longint'(b.w);
        h = longint'(b.h);
        r.s = sine_of(b.ang);
        r.c = sine_of(b.ang + obbsat_pkg::QUARTER);
        r.w_nz = (b.w != 0);
        r.h_nz = (b.h != 0);
        for (int k = 0; k < 4; k++)
        begin
            a  = (k & 1) ? 1 : -1;
            bb = (k & 2) ? 1 : -1;
            r.x[k] = 2*px + (w <<< obbsat_pkg::POS_FRAC_BITS) + scale_round(a*w*r.c - bb*h*r.s);
            r.y[k] = 2*py + (h <<< obbsat_pkg::POS_FRAC_BITS) + scale_round(a*w*r.s + bb*h*r.c);
        end
        return r;
    endfunction

    function automatic bit axis_separates(corners_t p, corners_t q, longint ux, longint uy);
        longint plo, phi, qlo, qhi, d;
        plo = ux*p.x[0] + uy*p.y[0];
        phi = plo;
        qlo = ux*q.x[0] + uy*q.y[0];
        qhi = qlo;
        for (int k = 1; k < 4; k++)
        begin
            d = ux*p.x[k] + uy*p.y[k];
            if (d < plo) plo = d;
            if (d > phi) phi = d;
            d = ux*q.x[k] + uy*q.y[k];
            if (d < qlo) qlo = d;
            if (d > qhi) qhi = d;
        end
        return (plo > qhi) || (phi < qlo);
    endfunction

    function automatic bit predict_overlap(box_in_t a, box_in_t b);
        corners_t ca, cb, o;
        bit hit;
        ca = make_corners(a);
        cb = make_corners(b);
        hit = 1'b1;
        for (int i = 0; i < 2; i++)
        begin
            o = (i == 0) ? ca : cb;
            if (o.w_nz && axis_separates(ca, cb, -o.s, o.c)) hit = 1'b0;
            if (o.h_nz && axis_separates(ca, cb, o.c, o.s)) hit = 1'b0;
        end
        return hit;
    endfunction

    function automatic box_in_t rand_box(bit near);
        box_in_t b;
        if (near)
        begin
            // small boxes in a small area so both outcomes show up
            b.px = $signed(24'($urandom_range(0, 16384))) - 24'sd8192;
            b.py = $signed(24'($urandom_range(0, 16384))) - 24'sd8192;
            b.w  = ($urandom_range(0, 15) == 0) ? 12'd0 : 12'($urandom_range(1, 60));
            b.h  = ($urandom_range(0, 15) == 0) ? 12'd0 : 12'($urandom_range(1, 60));
        end
        else
        begin
            b.px = 24'($urandom);
            b.py = 24'($urandom);
            b.w  = 12'($urandom);
            b.h  = 12'($urandom);
        end
        b.ang = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 3) << 14) : 16'($urandom);
        return b;
    endfunction

    function automatic box_in_t mk(int px, int py, int w, int h, int ang);
        box_in_t b;
        b.px = obbsat_pkg::POS_W'(px);
        b.py = obbsat_pkg::POS_W'(py);
        b.w = obbsat_pkg::SIZE_W'(w);
        b.h = obbsat_pkg::SIZE_W'(h);
        b.ang = obbsat_pkg::ANG_W'(ang);
        return b;
    endfunction

    task automatic send_pair(box_in_t a, box_in_t b);
        req.valid    <= 1'b1;
        req.a_pos_x  <= a.px;
        req.a_pos_y  <= a.py;
        req.a_width  <= a.w;
        req.a_height <= a.h;
        req.a_angle  <= a.ang;
        req.b_pos_x  <= b.px;
        req.b_pos_y  <= b.py;
        req.b_width  <= b.w;
        req.b_height <= b.h;
        req.b_angle  <= b.ang;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        sb.note_pair(predict_overlap(a, b));
    endtask

    task automatic pause_sender();
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic run_stimulus();
        box_in_t d[$];
        int burst;
        // touching edges, zero sizes, extremes, quadrant angles
        d = {d, mk(0, 0, 10, 10, 0),         mk(2560, 0, 10, 10, 0)};
        d = {d, mk(0, 0, 10, 10, 0),         mk(2561, 0, 10, 10, 0)};
        d = {d, mk(0, 0, 0, 10, 16384),      mk(0, 0, 10, 0, 32768)};
        d = {d, mk(0, 0, 0, 0, 0),           mk(100000, 0, 0, 0, 49152)};
        d = {d, mk(-8388608, -8388608, 4095, 4095, 65535)};
        d = {d, mk(8388607, 8388607, 4095, 4095, 8192)};
        d = {d, mk(-8388608, 8388607, 4095, 0, 8192)};
        d = {d, mk(8388607, -8388608, 0, 4095, 57344)};
        d = {d, mk(0, 0, 20, 5, 8192),       mk(3000, 3000, 20, 5, 24576)};
        d = {d, mk(0, 0, 1, 1, 40960),       mk(0, 0, 4095, 4095, 12345)};
        d = {d, mk(-256, -256, 3, 3, 65535), mk(-256, -256, 3, 3, 1)};
        for (int i = 0; i < d.size(); i += 2)
        begin
            send_pair(d[i], d[i+1]);
            pause_sender();
        end
        for (int n = 0; n < N_RANDOM; )
        begin
            burst = $urandom_range(1, 30);
            for (int k = 0; k < burst && n < N_RANDOM; k++, n++)
            begin
                if ($urandom_range(0, 4) == 0)
                    send_pair(rand_box(0), rand_box(0));
                else
                    send_pair(rand_box(1), rand_box(1));
            end
            pause_sender();
        end
        req.valid <= 1'b0;
    endtask

    // receiver stall pattern plus one long hold-off
    initial
    begin
        int cnt;
        rsp.ready <= 1'b0;
        cnt = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cnt++;
            if (cnt >= 200 && cnt < 260)
                rsp.ready <= 1'b0;
            else if ((cnt % 97) < 40)
                rsp.ready <= 1'b1;
            else
                rsp.ready <= ($urandom_range(0, 2) != 0);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
            sb.check_flag(rsp.overlap);
    end

    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        sb = new();
        rst_n <= 1'b0;
        req.valid <= 1'b0;
        req.a_pos_x <= '0;  req.a_pos_y <= '0;  req.a_width <= '0;
        req.a_height <= '0; req.a_angle <= '0;
        req.b_pos_x <= '0;  req.b_pos_y <= '0;  req.b_width <= '0;
        req.b_height <= '0; req.b_angle <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_stimulus();
        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (obbsat_pkg::STAGES + 20) @(posedge clk);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
